// ===== rtl/core/euler_totient_trial_division_top_macros.svh =====
// Assertion shorthands for the totient block. Both assume clk_i and rst_ni are in scope.
`ifndef EULER_TOTIENT_TRIAL_DIVISION_TOP_MACROS_SVH
`define EULER_TOTIENT_TRIAL_DIVISION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ettd_pkg.sv =====
`default_nettype none

package ettd_pkg;

  localparam int unsigned VAL_W     = 30;
  localparam int unsigned TOT_W     = 30;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned TBL_W     = 15;
  localparam int unsigned S_DATA_W  = 32;
  localparam int unsigned M_DATA_W  = 40;
  localparam int unsigned OUT_PAD_W = M_DATA_W - TOT_W - CNT_W;

endpackage

`default_nettype wire

// ===== rtl/core/euler_totient_trial_division_top.sv =====
// A zero value goes straight to the output register. Otherwise the table primes are tried in
// turn, using the bit-serial divider (one division per prime tried, one per factor removed
// and one per distinct factor).
// One value is in flight; the next is taken once the result sits in the output register.
// Reset is asynchronous and active low; afterwards the prime table is built by a sieve,
// during which s_axis_tready_o stays low.
`default_nettype none
`include "euler_totient_trial_division_top_macros.svh"

module euler_totient_trial_division_top #(
  parameter int unsigned PRIME_LIMIT = 32768,
  parameter int unsigned PRIME_COUNT = 3512,
  parameter int unsigned VALUE_WIDTH = 30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ettd_pkg::S_DATA_W-1:0]  s_axis_tdata_i,  // value
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ettd_pkg::M_DATA_W-1:0]  m_axis_tdata_o   // totient, distinct_primes
);

  import ettd_pkg::*;

  localparam int unsigned IW  = $clog2(PRIME_LIMIT);
  localparam int unsigned PW  = $clog2(PRIME_COUNT);
  localparam int unsigned PCW = $clog2(PRIME_COUNT + 1);
  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned SQW = 2 * IW;
  localparam int unsigned QSW = 2 * TBL_W;
  localparam int unsigned XW  = (VW > QSW) ? VW : QSW;
  localparam int unsigned MW  = 2 * VW;

  localparam logic [IW-1:0]  LAST_CAND = IW'(PRIME_LIMIT - 1);
  localparam logic [SQW-1:0] LIMIT_SQ  = SQW'(PRIME_LIMIT);
  localparam logic [IW:0]    LIMIT_J   = (IW + 1)'(PRIME_LIMIT);
  localparam logic [PCW-1:0] COUNT_MAX = PCW'(PRIME_COUNT);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_SRD   = 4'd1;
  localparam logic [3:0] ST_SCHK  = 4'd2;
  localparam logic [3:0] ST_SMARK = 4'd3;
  localparam logic [3:0] ST_IDLE  = 4'd4;
  localparam logic [3:0] ST_FETCH = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_TEST  = 4'd7;
  localparam logic [3:0] ST_RGO   = 4'd8;
  localparam logic [3:0] ST_RWAIT = 4'd9;
  localparam logic [3:0] ST_PGO   = 4'd10;
  localparam logic [3:0] ST_PWAIT = 4'd11;
  localparam logic [3:0] ST_MUL   = 4'd12;
  localparam logic [3:0] ST_TAIL  = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0]       st_q, st_d;
  logic [IW-1:0]    i_q, i_d;
  logic [IW:0]      j_q, j_d;
  logic [SQW-1:0]   sq_q, sq_d;
  logic [PCW-1:0]   pcnt_q, pcnt_d;
  logic [PCW-1:0]   idx_q, idx_d;
  logic [VW-1:0]    rest_q, rest_d;
  logic [VW-1:0]    phi_q, phi_d;
  logic [VW-1:0]    dv_q, dv_d;
  logic [VW-1:0]    mq_q, mq_d;
  logic [TBL_W-1:0] q_q, q_d;
  logic [QSW-1:0]   qsq_q, qsq_d;
  logic             hit_q, hit_d;
  logic             tail_q, tail_d;
  logic [CNT_W-1:0] found_q, found_d;
  logic             ovalid_q, ovalid_d;
  logic [TOT_W-1:0] otot_q, otot_d;
  logic [CNT_W-1:0] ocnt_q, ocnt_d;

  logic             mk_we;
  logic [IW-1:0]    mk_waddr;
  logic             mk_wdata;
  logic             mk_rdata;
  logic             tb_we;
  logic [TBL_W-1:0] tb_rdata;

  logic             div_start;
  logic [VW-1:0]    div_dividend;
  logic             div_done;
  logic [VW-1:0]    div_quot;
  logic [VW-1:0]    div_rem;

  logic [VW-1:0]    val_in;
  logic             mk_prime;
  logic [PCW-1:0]   pc_inc;
  logic [IW:0]      j_nxt;
  logic             i_last;
  logic             out_free;
  logic [MW-1:0]    prod;

  // Composite marks for the sieve that builds the table after reset.
  ettd_ram #(
    .WIDTH (1),
    .DEPTH (PRIME_LIMIT)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .raddr_i (i_q),
    .rdata_o (mk_rdata)
  );

  ettd_ram #(
    .WIDTH (TBL_W),
    .DEPTH (PRIME_COUNT)
  ) u_prime_ram (
    .clk_i   (clk_i),
    .we_i    (tb_we),
    .waddr_i (pcnt_q[PW-1:0]),
    .wdata_i (i_q[TBL_W-1:0]),
    .raddr_i (idx_q[PW-1:0]),
    .rdata_o (tb_rdata)
  );

  ettd_div #(
    .WIDTH (VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (dv_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign val_in   = VW'(s_axis_tdata_i[VAL_W-1:0]);
  assign mk_prime = ~mk_rdata;
  assign pc_inc   = pcnt_q + PCW'(1);
  assign j_nxt    = j_q + (IW + 1)'(i_q);
  assign i_last   = (i_q == LAST_CAND);
  assign out_free = ~ovalid_q | m_axis_tready_i;
  assign prod     = {{VW{1'b0}}, mq_q} * {{VW{1'b0}}, dv_q - VW'(1)};

  always_comb begin
    st_d         = st_q;
    i_d          = i_q;
    j_d          = j_q;
    sq_d         = sq_q;
    pcnt_d       = pcnt_q;
    idx_d        = idx_q;
    rest_d       = rest_q;
    phi_d        = phi_q;
    dv_d         = dv_q;
    mq_d         = mq_q;
    q_d          = q_q;
    qsq_d        = qsq_q;
    hit_d        = hit_q;
    tail_d       = tail_q;
    found_d      = found_q;
    ovalid_d     = ovalid_q & ~m_axis_tready_i;
    otot_d       = otot_q;
    ocnt_d       = ocnt_q;
    mk_we        = 1'b0;
    mk_waddr     = j_q[IW-1:0];
    mk_wdata     = 1'b1;
    tb_we        = 1'b0;
    div_start    = 1'b0;
    div_dividend = rest_q;

    case (st_q)
      ST_CLR: begin
        mk_we    = 1'b1;
        mk_waddr = i_q;
        mk_wdata = 1'b0;
        if (i_last) begin
          i_d  = IW'(2);
          st_d = ST_SRD;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      ST_SRD: begin
        sq_d = SQW'(i_q) * SQW'(i_q);
        st_d = ST_SCHK;
      end
      ST_SCHK: begin
        if (mk_prime) begin
          tb_we  = 1'b1;
          pcnt_d = pc_inc;
        end
        if ((mk_prime && (pc_inc == COUNT_MAX)) || i_last) begin
          st_d = ST_IDLE;
        end else if (mk_prime && (sq_q < LIMIT_SQ)) begin
          j_d  = sq_q[IW:0];
          st_d = ST_SMARK;
        end else begin
          i_d  = i_q + IW'(1);
          st_d = ST_SRD;
        end
      end
      ST_SMARK: begin
        mk_we = 1'b1;
        if (j_nxt >= LIMIT_J) begin
          i_d  = i_q + IW'(1);
          st_d = ST_SRD;
        end else begin
          j_d = j_nxt;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          rest_d  = val_in;
          phi_d   = val_in;
          found_d = '0;
          idx_d   = '0;
          hit_d   = 1'b0;
          tail_d  = 1'b0;
          st_d    = (val_in == '0) ? ST_OUT : ST_FETCH;
        end
      end
      ST_FETCH: begin
        st_d = (idx_q == pcnt_q) ? ST_TAIL : ST_SQ;
      end
      ST_SQ: begin
        q_d   = tb_rdata;
        qsq_d = QSW'(tb_rdata) * QSW'(tb_rdata);
        dv_d  = VW'(tb_rdata);
        st_d  = ST_TEST;
      end
      ST_TEST: begin
        if ((q_q < TBL_W'(2)) || (XW'(qsq_q) > XW'(rest_q))) begin
          st_d = ST_TAIL;
        end else begin
          st_d = ST_RGO;
        end
      end
      ST_RGO: begin
        div_start    = 1'b1;
        div_dividend = rest_q;
        st_d         = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (div_done) begin
          if (div_rem == '0) begin
            rest_d = div_quot;
            if (hit_q) begin
              st_d = ST_RGO;
            end else begin
              hit_d   = 1'b1;
              found_d = found_q + CNT_W'(1);
              st_d    = ST_PGO;
            end
          end else begin
            hit_d = 1'b0;
            idx_d = idx_q + PCW'(1);
            st_d  = ST_FETCH;
          end
        end
      end
      ST_PGO: begin
        div_start    = 1'b1;
        div_dividend = phi_q;
        st_d         = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (div_done) begin
          mq_d = div_quot;
          st_d = ST_MUL;
        end
      end
      ST_MUL: begin
        phi_d = prod[VW-1:0];
        st_d  = tail_q ? ST_OUT : ST_RGO;
      end
      ST_TAIL: begin
        if (rest_q > VW'(1)) begin
          found_d = found_q + CNT_W'(1);
          dv_d    = rest_q;
          tail_d  = 1'b1;
          st_d    = ST_PGO;
        end else begin
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          otot_d   = TOT_W'(phi_q);
          ocnt_d   = found_q;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLR;
      i_q      <= '0;
      pcnt_q   <= '0;
      idx_q    <= '0;
      hit_q    <= 1'b0;
      tail_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      i_q      <= i_d;
      pcnt_q   <= pcnt_d;
      idx_q    <= idx_d;
      hit_q    <= hit_d;
      tail_q   <= tail_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    sq_q    <= sq_d;
    rest_q  <= rest_d;
    phi_q   <= phi_d;
    dv_q    <= dv_d;
    mq_q    <= mq_d;
    q_q     <= q_d;
    qsq_q   <= qsq_d;
    found_q <= found_d;
    otot_q  <= otot_d;
    ocnt_q  <= ocnt_d;
  end

  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, ocnt_q, otot_q};

  `ETTD_ASSERT_IMP(a_walk_in_table, 1'b1, idx_q <= pcnt_q, "prime walk passed the table fill")
  `ETTD_ASSERT_IMP(a_fill_bound, 1'b1, pcnt_q <= COUNT_MAX, "prime table overfilled")
  `ETTD_ASSERT_NXT(a_rest_shrinks, (st_q == ST_RWAIT) && div_done, rest_q <= $past(rest_q), "cofactor grew")

endmodule

`default_nettype wire

// ===== rtl/core/ettd_ram.sv =====
`default_nettype none

module ettd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ettd_div.sv =====
`default_nettype none

module ettd_div #(
  parameter int unsigned WIDTH = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] dividend_i,
  input  logic [WIDTH-1:0] divisor_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  // One quotient bit per cycle by restoring division.
  assign shifted = {rem_q, quo_q[WIDTH-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
